// ----- design/ptw_pkg.sv -----
// Shared types, constants and a helper function of the four-level page table walker.
package ptw_pkg;

  localparam int TableFramesDefault = 16;
  localparam int EntriesPerTable    = 512;
  localparam int IdxW               = 9;

  localparam logic [63:0] Low2MibMask = 64'h0000_0000_001F_FFFF;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED  = 2'd1;
  localparam logic [1:0] ST_PRESENT     = 2'd2;
  localparam logic [1:0] ST_FRAME_FAULT = 2'd3;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_UNMAP  = 3'd3,
    ACT_MAP2M  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ADDR_CLEAR,
    ADDR_DIRECT,
    ADDR_WALK,
    ADDR_NEXT
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_DIRECT,
    WD_MAP
  } wdata_sel_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] map_flags;
    logic [3:0]  entry_frame;
    logic [8:0]  entry_index;
    logic [63:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [3:0]  pte_frame;
    logic [8:0]  pte_index;
    logic        flush_tlb;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       mem_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       advance;
    logic       set_status;
    logic [1:0] status;
    logic       capture_rv;
    logic       capture_pte;
    logic       set_flush;
    logic       push_out;
    logic       clr_step;
  } cmd_t;

  typedef struct packed {
    action_e    action;
    logic       ef_fault;
    logic       root_fault;
    logic       present;
    logic       huge;
    logic       next_fault;
    logic [1:0] level;
    logic       clear_last;
    logic       out_free;
  } stat_t;

  function automatic logic [IdxW-1:0] level_index(input logic [47:0] va,
                                                  input logic [1:0]  lvl);
    logic [IdxW-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ----- design/ptw_datapath.sv -----
// Datapath of the page table walker: table memory, item and walk registers, result register.
module ptw_datapath #(
  parameter int TABLE_FRAMES = ptw_pkg::TableFramesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptw_pkg::cmd_t       cmd_i,
  output ptw_pkg::stat_t      stat_o,
  input  ptw_pkg::in_item_t   in_item_i,
  input  logic [3:0]          root_frame_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output ptw_pkg::out_item_t  out_item_o
);
  import ptw_pkg::*;

  localparam int FrameW = $clog2(TABLE_FRAMES);
  localparam int AddrW  = FrameW + IdxW;
  localparam int Depth  = TABLE_FRAMES * EntriesPerTable;

  logic [63:0]       mem [Depth];
  in_item_t          item_q;
  logic [FrameW-1:0] frame_q;
  logic [1:0]        level_q;
  logic [63:0]       rdata_q;
  out_item_t         res_q;
  out_item_t         out_q;
  logic              out_valid_q;
  logic [AddrW-1:0]  clr_q;
  logic [AddrW-1:0]  addr;
  logic [63:0]       wdata;

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CLEAR:  addr = clr_q;
      ADDR_DIRECT: addr = {FrameW'(item_q.entry_frame), item_q.entry_index};
      ADDR_NEXT:   addr = {rdata_q[12 +: FrameW],
                           level_index(item_q.virt_addr, level_q + 2'd1)};
      default:     addr = {frame_q, level_index(item_q.virt_addr, level_q)};
    endcase
  end

  always_comb begin
    case (cmd_i.wdata_sel)
      WD_DIRECT: wdata = item_q.entry_value;
      WD_MAP:    wdata = (64'(item_q.phys_addr) & ~Low2MibMask) | item_q.map_flags;
      default:   wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[addr] <= wdata;
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q  <= in_item_i;
      frame_q <= FrameW'(root_frame_i);
      level_q <= LVL_PML4;
      res_q   <= '0;
    end else begin
      if (cmd_i.advance) begin
        frame_q <= rdata_q[12 +: FrameW];
        level_q <= level_q + 2'd1;
      end
      if (cmd_i.set_status) begin
        res_q.status <= cmd_i.status;
      end
      if (cmd_i.capture_rv) begin
        res_q.read_value <= rdata_q;
      end
      if (cmd_i.capture_pte) begin
        res_q.pte_frame <= 4'(frame_q);
        res_q.pte_index <= level_index(item_q.virt_addr, LVL_PT);
      end
      if (cmd_i.set_flush) begin
        res_q.flush_tlb <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.action     = action_e'(item_q.action);
  assign stat_o.ef_fault   = 32'(item_q.entry_frame) >= 32'(TABLE_FRAMES);
  assign stat_o.root_fault = 32'(root_frame_i) >= 32'(TABLE_FRAMES);
  assign stat_o.present    = rdata_q[0];
  assign stat_o.huge       = rdata_q[7];
  assign stat_o.next_fault = rdata_q[51:12] >= 40'(TABLE_FRAMES);
  assign stat_o.level      = level_q;
  assign stat_o.clear_last = clr_q == AddrW'(Depth - 1);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- design/ptw_ctrl.sv -----
// Controller state machine that sequences clearing, direct accesses and table walks.
module ptw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptw_pkg::stat_t stat_i,
  output ptw_pkg::cmd_t  cmd_o
);
  import ptw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_WALK;
    cmd_o.wdata_sel = WD_ZERO;
    state_d        = state_q;
    in_ready_o     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_CLEAR;
        cmd_o.clr_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.action)
          ACT_WRITE: begin
            if (stat_i.ef_fault) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FRAME_FAULT;
            end else begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.addr_sel  = ADDR_DIRECT;
              cmd_o.wdata_sel = WD_DIRECT;
            end
          end
          ACT_READ: begin
            if (stat_i.ef_fault) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FRAME_FAULT;
            end else begin
              cmd_o.addr_sel = ADDR_DIRECT;
              state_d = S_EVAL;
            end
          end
          ACT_LOOKUP, ACT_UNMAP, ACT_MAP2M: begin
            if (stat_i.root_fault) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FRAME_FAULT;
            end else begin
              state_d = S_EVAL;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_EVAL: begin
        state_d = S_DONE;
        if (stat_i.action == ACT_READ) begin
          cmd_o.capture_rv = 1'b1;
        end else begin
          case (stat_i.level)
            LVL_PML4, LVL_PDPT: begin
              if (!stat_i.present) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_NOT_MAPPED;
              end else if (stat_i.next_fault) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_FRAME_FAULT;
              end else begin
                cmd_o.advance  = 1'b1;
                cmd_o.addr_sel = ADDR_NEXT;
                state_d = S_EVAL;
              end
            end
            LVL_PD: begin
              if (stat_i.action == ACT_MAP2M) begin
                if (stat_i.present) begin
                  cmd_o.set_status = 1'b1;
                  cmd_o.status     = ST_PRESENT;
                end else begin
                  cmd_o.mem_we    = 1'b1;
                  cmd_o.wdata_sel = WD_MAP;
                end
              end else if (!stat_i.present || stat_i.huge) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_NOT_MAPPED;
              end else if (stat_i.next_fault) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_FRAME_FAULT;
              end else begin
                cmd_o.advance  = 1'b1;
                cmd_o.addr_sel = ADDR_NEXT;
                state_d = S_EVAL;
              end
            end
            default: begin
              if (stat_i.action == ACT_UNMAP && !stat_i.present) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_NOT_MAPPED;
              end else begin
                cmd_o.capture_rv  = 1'b1;
                cmd_o.capture_pte = 1'b1;
                if (stat_i.action == ACT_UNMAP) begin
                  cmd_o.set_flush = 1'b1;
                  cmd_o.mem_we    = 1'b1;
                end
              end
            end
          endcase
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/four_level_page_table_walker.sv -----
// Top level of the four-level page table walker with its configuration register.
//
//   Port group   Direction  Transfer when           Carries
//   in_*         in         in_valid_i & in_ready_o  one action (in_item_t)
//   out_*        out        out_valid_o & out_ready_i one result (out_item_t)
//   APB p*       in/out     psel & penable & pwrite  root frame register
//
// After reset a clearing pass zeroes all TABLE_FRAMES * 512 entries of the table memory
// (8192 by default), and no item is taken until it ends.
// A direct write is done in the decode state, a direct read also passes the evaluate state,
// and a map, lookup or unmap walks the levels in the evaluate state; faults end a walk early.
// The done and idle states follow before the next transfer in, so no item overlaps another.
// The single-port table memory with its registered read paces the walk: one level per cycle.
// A waiting result does not block the next transfer in; only the push of the next result stalls.
module four_level_page_table_walker #(
  parameter int TABLE_FRAMES = ptw_pkg::TableFramesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptw_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ptw_pkg::*;

  logic [3:0] root_q;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      root_q <= pwdata[3:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : 32'(root_q);

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptw_datapath #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_item_i    (in_item_i),
    .root_frame_i (root_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o)
  );

endmodule

// ----- design/ptw_checker.sv -----
// Port-level assertions for the page table walker and their bind to the top level.
module ptw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ptw_pkg::out_item_t out_item_o
);
  import ptw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer accepted while an item is in work");

  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.flush_tlb |->
      out_item_o.status == ST_OK && out_item_o.read_value[0])
    else $error("flush without a cleared present entry");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |->
      out_item_o.read_value == 64'd0 && !out_item_o.flush_tlb &&
      out_item_o.pte_frame == 4'd0 && out_item_o.pte_index == 9'd0)
    else $error("failed action returned data");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
